// ===== hw/rtl/apbf_pkg.sv =====
// Shared constants, types and state codes for the articulation point and bridge finder.
package apbf_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MAX_EDGES    = 256;
	localparam int VW           = $clog2(MAX_VERTICES);
	localparam int VCW          = VW + 1;
	localparam int EAW          = $clog2(MAX_EDGES);
	localparam int ECW          = EAW + 1;

	typedef enum logic [1:0] {
		MODE_ADD     = 2'd0,
		MODE_COMPUTE = 2'd1,
		MODE_CLEAR   = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROOT,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_BACK,
		ST_POP,
		ST_POP_W,
		ST_POP_M,
		ST_COUNT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [5:0] end_a;
		logic [5:0] end_b;
	} cmd_t;

	typedef struct packed {
		logic       has_articulation;
		logic       has_bridge;
		logic [6:0] articulation_count;
		logic [5:0] bridge_count;
		logic       edges_dropped;
	} res_t;

endpackage

// ===== hw/rtl/articulation_point_bridge_finder.sv =====
// Top level: edge store and depth-first walk sequencer for articulation points and bridges.
//
// Usage:
//   Command channel (cmd_valid/cmd_ready, payload cmd): mode 0 adds edge
//   end_a-end_b, mode 1 runs the walk and reports, mode 2 empties the edge
//   store and the drop flag, mode 3 is ignored.
//   Result channel (res_valid/res_ready, payload res): one transaction per
//   compute command.
//   wr_en/wr_data set vertex_count; write it only while the block is idle.
// Sequencing:
//   Add, clear and unused commands are accepted back to back.
//   A compute is sequenced through one edge-store read port: each vertex
//   on the walk reads and checks every stored edge, then ends its list; a
//   back edge adds a low-link update, a tree-edge return passes the pop,
//   pop-wait and merge states, and each root candidate is tried in turn;
//   then all 64 cut flags are counted and the result is handed over.
//   cmd_ready is low for the whole compute.
// Reset: arst_n clears edge count, drop flag, vertex_count to 1 and the
//   sequencer; stores need no clearing.
// Stall: a result is held in the output register until taken; a new
//   result waits in the sequencer while the previous one is pending.
module articulation_point_bridge_finder
	import apbf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       res_valid,
	input  logic       res_ready,
	output res_t       res,
	input  logic       wr_en,
	input  logic [6:0] wr_data
);

	state_t state_q, state_d;

	logic [6:0]        vcount_q;
	logic [ECW-1:0]    edge_total_q;
	logic              drop_q;
	logic [MAX_VERTICES-1:0] visited_q, cut_q;
	logic [VCW-1:0]    time_q;
	logic [VCW-1:0]    root_q;
	logic [VCW-1:0]    root_child_q;
	logic [VCW-1:0]    sp_q;
	logic [VW-1:0]     cur_u_q;
	logic [ECW-1:0]    cur_e_q;
	logic [VW-1:0]     cur_low_q;
	logic [VW:0]       cur_par_q;
	logic [VW-1:0]     bridges_q;
	logic [VCW-1:0]    cnt_q;
	logic [6:0]        art_q;
	logic              res_valid_q;
	res_t              res_q;

	logic [VCW-1:0]    nv;
	logic              cmd_fire;

	// Memory ports
	logic [2*VW-1:0]   edge_rd;
	logic [VW-1:0]     stk_rd, low_rd, disc_rd;
	logic [ECW-1:0]    pos_rd;
	logic [VW:0]       par_rd;
	logic              add_ok, push, enter_root;
	logic [VW-1:0]     disc_raddr, disc_waddr;

	// Edge decode
	logic [VW-1:0]     ea, eb, v;
	logic              hit, is_par;

	assign nv = (vcount_q > 7'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : VCW'(vcount_q);
	assign cmd_fire = cmd_valid && cmd_ready;
	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res = res_q;

	assign add_ok = cmd_fire && (cmd.mode == MODE_ADD) && (VCW'(cmd.end_a) < nv)
		&& (VCW'(cmd.end_b) < nv) && (edge_total_q < ECW'(MAX_EDGES));

	assign ea = edge_rd[2*VW-1:VW];
	assign eb = edge_rd[VW-1:0];
	assign hit = (VCW'(ea) < nv) && (VCW'(eb) < nv) && (ea == cur_u_q || eb == cur_u_q);
	assign v = (ea == cur_u_q) ? eb : ea;
	assign is_par = !cur_par_q[VW] && (v == cur_par_q[VW-1:0]);
	assign push = (state_q == ST_SCAN_CHK) && hit && !is_par && !visited_q[v];
	assign enter_root = (state_q == ST_ROOT) && (root_q < nv) && !visited_q[root_q[VW-1:0]];
	assign disc_raddr = (state_q == ST_SCAN_CHK) ? v : stk_rd;
	assign disc_waddr = push ? v : root_q[VW-1:0];

	apbf_ram #(.W(2*VW), .D(MAX_EDGES)) u_edges (
		.clk(clk), .we(add_ok), .waddr(edge_total_q[EAW-1:0]),
		.wdata({cmd.end_a, cmd.end_b}), .raddr(cur_e_q[EAW-1:0]), .rdata(edge_rd)
	);
	apbf_ram #(.W(VW), .D(MAX_VERTICES)) u_stack (
		.clk(clk), .we(push), .waddr(sp_q[VW-1:0]), .wdata(cur_u_q),
		.raddr(VW'(sp_q - 1'b1)), .rdata(stk_rd)
	);
	apbf_ram #(.W(ECW), .D(MAX_VERTICES)) u_pos (
		.clk(clk), .we(push), .waddr(cur_u_q), .wdata(cur_e_q + 1'b1),
		.raddr(stk_rd), .rdata(pos_rd)
	);
	apbf_ram #(.W(VW), .D(MAX_VERTICES)) u_low (
		.clk(clk), .we(push), .waddr(cur_u_q), .wdata(cur_low_q),
		.raddr(stk_rd), .rdata(low_rd)
	);
	apbf_ram #(.W(VW+1), .D(MAX_VERTICES)) u_par (
		.clk(clk), .we(push), .waddr(cur_u_q), .wdata(cur_par_q),
		.raddr(stk_rd), .rdata(par_rd)
	);
	apbf_ram #(.W(VW), .D(MAX_VERTICES)) u_disc (
		.clk(clk), .we(push || enter_root), .waddr(disc_waddr),
		.wdata(time_q[VW-1:0]), .raddr(disc_raddr), .rdata(disc_rd)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire && cmd.mode == MODE_COMPUTE) state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (root_q >= nv) state_d = ST_COUNT;
				else if (enter_root) state_d = ST_SCAN_RD;
			end
			ST_SCAN_RD: state_d = (cur_e_q >= edge_total_q) ? ST_POP : ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (hit && !is_par && visited_q[v]) state_d = ST_BACK;
				else state_d = ST_SCAN_RD;
			end
			ST_BACK: state_d = ST_SCAN_RD;
			ST_POP: state_d = (sp_q == '0) ? ST_ROOT : ST_POP_W;
			ST_POP_W: state_d = ST_POP_M;
			ST_POP_M: state_d = ST_SCAN_RD;
			ST_COUNT: begin
				if (cnt_q == VCW'(MAX_VERTICES - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!res_valid_q || res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration, edge count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q     <= 7'd1;
			edge_total_q <= '0;
			drop_q       <= 1'b0;
		end else begin
			if (wr_en) vcount_q <= wr_data;
			if (add_ok) begin
				edge_total_q <= edge_total_q + 1'b1;
			end else if (cmd_fire && cmd.mode == MODE_ADD) begin
				drop_q <= 1'b1;
			end
			if (cmd_fire && cmd.mode == MODE_CLEAR) begin
				edge_total_q <= '0;
				drop_q       <= 1'b0;
			end
		end
	end

	// Walk datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			cut_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					visited_q    <= '0;
					cut_q        <= '0;
					time_q       <= '0;
					root_q       <= '0;
					bridges_q    <= '0;
					cnt_q        <= '0;
					art_q        <= '0;
				end
				ST_ROOT: begin
					if (enter_root) begin
						visited_q[root_q[VW-1:0]] <= 1'b1;
						cur_u_q      <= root_q[VW-1:0];
						cur_e_q      <= '0;
						cur_low_q    <= time_q[VW-1:0];
						cur_par_q    <= {1'b1, {VW{1'b0}}};
						time_q       <= time_q + 1'b1;
						sp_q         <= '0;
						root_child_q <= '0;
					end else if (root_q < nv) begin
						root_q <= root_q + 1'b1;
					end
				end
				ST_SCAN_CHK: begin
					cur_e_q <= cur_e_q + 1'b1;
					if (push) begin
						visited_q[v] <= 1'b1;
						if (VCW'(cur_u_q) == root_q) root_child_q <= root_child_q + 1'b1;
						sp_q      <= sp_q + 1'b1;
						cur_u_q   <= v;
						cur_e_q   <= '0;
						cur_low_q <= time_q[VW-1:0];
						cur_par_q <= {1'b0, cur_u_q};
						time_q    <= time_q + 1'b1;
					end
				end
				ST_BACK: begin
					if (disc_rd < cur_low_q) cur_low_q <= disc_rd;
				end
				ST_POP: begin
					if (sp_q == '0) begin
						if (root_child_q > VCW'(1)) cut_q[root_q[VW-1:0]] <= 1'b1;
						root_q <= root_q + 1'b1;
					end
				end
				ST_POP_M: begin
					// Fold the finished child into its parent
					if (cur_low_q > disc_rd) bridges_q <= bridges_q + 1'b1;
					if (VCW'(stk_rd) != root_q && cur_low_q >= disc_rd) cut_q[stk_rd] <= 1'b1;
					cur_low_q <= (cur_low_q < low_rd) ? cur_low_q : low_rd;
					cur_u_q   <= stk_rd;
					cur_e_q   <= pos_rd;
					cur_par_q <= par_rd;
					sp_q      <= sp_q - 1'b1;
				end
				ST_COUNT: begin
					cnt_q <= cnt_q + 1'b1;
					art_q <= art_q + 7'(cut_q[cnt_q[VW-1:0]]);
				end
				default: begin
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!res_valid_q || res_ready)) begin
				res_valid_q              <= 1'b1;
				res_q.has_articulation   <= (art_q != '0);
				res_q.has_bridge         <= (bridges_q != '0);
				res_q.articulation_count <= art_q;
				res_q.bridge_count       <= bridges_q;
				res_q.edges_dropped      <= drop_q;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edge_total_q <= ECW'(MAX_EDGES)) else $error("edge count beyond store");
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && cmd.mode == MODE_COMPUTE |=> !cmd_ready) else $error("ready during walk");
	a_visit_time: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> $countones(visited_q) == int'(time_q))
		else $error("visit count and time disagree");
	a_bridge_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_q.has_bridge == (res_q.bridge_count != '0))
		else $error("bridge flag mismatch");

endmodule

// ===== hw/rtl/apbf_ram.sv =====
// Generic single-write, single-read memory with registered read data.
module apbf_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
